>>> rtl/host_session_table_assert.svh
// ----------------------------------------------------------------------------
// host_session_table_assert.svh
// Assertion macros shared by the session table RTL.
// ----------------------------------------------------------------------------
`ifndef HOST_SESSION_TABLE_ASSERT_SVH
`define HOST_SESSION_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define HST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset as well
`define HST_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define HST_ASSERT(label, prop, msg)
`define HST_ASSERT_RST(label, prop, msg)

`endif

`endif

>>> rtl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Types and constants of the host session table.
// ----------------------------------------------------------------------------
package hst_pkg;

    localparam int SLOTS     = 4;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SESS_W    = 32;
    localparam int TIME_W    = 48;
    localparam int TMO_W     = 32;
    localparam int KIND_W    = 3;
    localparam int MASK_W    = 4;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 40;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd5000000;

    localparam logic [KIND_W-1:0] KIND_HELLO = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BYE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESET = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd4;

    typedef struct packed {
        logic [6:0]        pad;
        logic [TIME_W-1:0] now_us;
        logic              addr_ok;
        logic [SESS_W-1:0] session;
    } hst_in_t;

    typedef struct packed {
        logic              pad;
        logic [MASK_W-1:0] expired_mask;
        logic              detached_now;
        logic              any_attached;
        logic [SESS_W-1:0] history_to;
        logic              accepted;
    } hst_out_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;
        logic              scan;
        logic              apply;
        logic              out_load;
        logic [SLOT_W-1:0] idx;
    } hst_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_block;
    } hst_stat_t;

endpackage

>>> rtl/hst_ctrl.sv
// ----------------------------------------------------------------------------
// hst_ctrl
// Sequencer: takes an item, walks the slots, applies the update, posts result.
// ----------------------------------------------------------------------------
`include "host_session_table_assert.svh"

module hst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hst_pkg::hst_stat_t stat,
    output hst_pkg::hst_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_FINISH
    } state_t;

    localparam logic [hst_pkg::SLOT_W-1:0] LAST_IDX = hst_pkg::SLOT_W'(hst_pkg::SLOTS - 1);

    state_t                      state_reg, state_next;
    logic [hst_pkg::SLOT_W-1:0]  idx_reg, idx_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.load     = 1'b0;
        cmd.scan     = 1'b0;
        cmd.apply    = 1'b0;
        cmd.out_load = 1'b0;
        cmd.idx      = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_APPLY;
                end else begin
                    idx_next = idx_reg + hst_pkg::SLOT_W'(1);
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the result register can take the item
                if (!stat.out_block) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    `HST_ASSERT(a_accept_starts_scan,
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN && idx_reg == '0),
        "accept did not start scan at slot 0")
    `HST_ASSERT(a_apply_after_scan, cmd.apply |-> $past(cmd.scan), "apply without a finished scan")
    `HST_ASSERT(a_finish_holds,
        (state_reg == ST_FINISH && stat.out_block) |=> (state_reg == ST_FINISH),
        "left finish while the result register was full")

endmodule

>>> rtl/hst_dp.sv
// ----------------------------------------------------------------------------
// hst_dp
// Slot table, per-slot scan logic, update step and result register.
// ----------------------------------------------------------------------------
`include "host_session_table_assert.svh"

module hst_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hst_pkg::TMO_W-1:0]     cfg_wdata,
    input  logic [hst_pkg::KIND_W-1:0]    s_tuser,
    input  logic [hst_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hst_pkg::M_TDATA_W-1:0] m_tdata,
    input  hst_pkg::hst_cmd_t             cmd,
    output hst_pkg::hst_stat_t            stat
);

    hst_pkg::hst_in_t             in_w;
    hst_pkg::hst_out_t            out_reg;

    // latched item, and the idle timeout
    logic [hst_pkg::KIND_W-1:0]   kind_reg;
    logic [hst_pkg::SESS_W-1:0]   session_reg;
    logic                         addr_ok_reg;
    logic [hst_pkg::TIME_W-1:0]   now_reg;
    logic [hst_pkg::TMO_W-1:0]    timeout_reg;

    // table
    logic [hst_pkg::SESS_W-1:0]   slot_session_reg [hst_pkg::SLOTS];
    logic [hst_pkg::TIME_W-1:0]   slot_seen_reg    [hst_pkg::SLOTS];
    logic [hst_pkg::SLOTS-1:0]    slot_hist_reg;
    logic                         attached_reg;

    // scan results
    logic                         found_reg, free_reg, any_reg, handed_reg;
    logic [hst_pkg::SLOT_W-1:0]   found_idx_reg, free_idx_reg, min_idx_reg;
    logic [hst_pkg::TIME_W-1:0]   min_seen_reg;
    logic                         accepted_reg, detached_reg;
    logic [hst_pkg::SESS_W-1:0]   history_reg;
    logic [hst_pkg::MASK_W-1:0]   expired_reg;
    logic                         m_tvalid_reg;

    logic [hst_pkg::SESS_W-1:0]   cur_sess;
    logic [hst_pkg::TIME_W-1:0]   cur_seen;
    logic [hst_pkg::TIME_W-1:0]   age;
    logic                         expire;
    logic                         is_tick, msg_act, is_note, do_note;
    logic [hst_pkg::SLOT_W-1:0]   pick;

    assign in_w     = hst_pkg::hst_in_t'(s_tdata);
    assign cur_sess = slot_session_reg[cmd.idx];
    assign cur_seen = slot_seen_reg[cmd.idx];
    assign age      = now_reg - cur_seen;
    assign expire   = (cur_sess != '0) && (now_reg >= cur_seen) &&
                      (age > {{(hst_pkg::TIME_W - hst_pkg::TMO_W){1'b0}}, timeout_reg});

    assign is_tick  = (kind_reg == hst_pkg::KIND_TICK);
    assign msg_act  = (session_reg != '0) && addr_ok_reg;
    assign is_note  = msg_act && ((kind_reg == hst_pkg::KIND_HELLO) ||
                                  (kind_reg == hst_pkg::KIND_DATA) ||
                                  (kind_reg == hst_pkg::KIND_RESET));
    // data and reset only refresh a known session
    assign do_note  = is_note && (found_reg || (kind_reg == hst_pkg::KIND_HELLO));
    assign pick     = found_reg ? found_idx_reg : (free_reg ? free_idx_reg : min_idx_reg);

    assign stat.out_block = m_tvalid_reg && !m_tready;
    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= hst_pkg::TIMEOUT_RESET;
            for (int i = 0; i < hst_pkg::SLOTS; i++) begin
                slot_session_reg[i] <= '0;
                slot_seen_reg[i]    <= '0;
            end
            slot_hist_reg <= '0;
            attached_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end

            if (cmd.scan) begin
                if (is_tick) begin
                    if (expire) begin
                        slot_session_reg[cmd.idx] <= '0;
                        slot_seen_reg[cmd.idx]    <= '0;
                        slot_hist_reg[cmd.idx]    <= 1'b0;
                    end else if (cur_sess != '0) begin
                        if (slot_hist_reg[cmd.idx] && !handed_reg) begin
                            slot_hist_reg[cmd.idx] <= 1'b0;
                        end
                    end
                end else if (msg_act && kind_reg == hst_pkg::KIND_BYE &&
                             cur_sess == session_reg) begin
                    slot_session_reg[cmd.idx] <= '0;
                    slot_seen_reg[cmd.idx]    <= '0;
                    slot_hist_reg[cmd.idx]    <= 1'b0;
                end
            end

            if (cmd.apply) begin
                if (do_note) begin
                    slot_session_reg[pick] <= session_reg;
                    slot_seen_reg[pick]    <= now_reg;
                    if (!found_reg) begin
                        slot_hist_reg[pick] <= 1'b1;
                    end
                    attached_reg <= 1'b1;
                end else if (is_tick && !any_reg && attached_reg) begin
                    attached_reg <= 1'b0;
                end
            end

            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working registers of the current item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg      <= s_tuser;
            session_reg   <= in_w.session;
            addr_ok_reg   <= in_w.addr_ok;
            now_reg       <= in_w.now_us;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            any_reg       <= 1'b0;
            handed_reg    <= 1'b0;
            found_idx_reg <= '0;
            free_idx_reg  <= '0;
            min_idx_reg   <= '0;
            min_seen_reg  <= '0;
            accepted_reg  <= 1'b0;
            detached_reg  <= 1'b0;
            history_reg   <= '0;
            expired_reg   <= '0;
        end

        if (cmd.scan) begin
            if (is_tick) begin
                if (expire) begin
                    for (int j = 0; j < hst_pkg::MASK_W; j++) begin
                        if (int'(cmd.idx) == j) begin
                            expired_reg[j] <= 1'b1;
                        end
                    end
                end else if (cur_sess != '0) begin
                    any_reg <= 1'b1;
                    if (slot_hist_reg[cmd.idx] && !handed_reg) begin
                        history_reg <= cur_sess;
                        handed_reg  <= 1'b1;
                    end
                end
            end else begin
                if (!found_reg && cur_sess == session_reg) begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= cmd.idx;
                end
                if (!free_reg && cur_sess == '0) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cmd.idx;
                end
                // oldest slot, first one wins ties
                if (cmd.idx == '0 || cur_seen < min_seen_reg) begin
                    min_idx_reg  <= cmd.idx;
                    min_seen_reg <= cur_seen;
                end
            end
        end

        if (cmd.apply) begin
            accepted_reg <= do_note && (kind_reg != hst_pkg::KIND_HELLO);
            detached_reg <= is_tick && !any_reg && attached_reg;
        end

        if (cmd.out_load) begin
            out_reg.pad          <= 1'b0;
            out_reg.accepted     <= accepted_reg;
            out_reg.history_to   <= history_reg;
            out_reg.any_attached <= attached_reg;
            out_reg.detached_now <= detached_reg;
            out_reg.expired_mask <= expired_reg;
        end
    end

    `HST_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")
    `HST_ASSERT(a_detach_excl,
        m_tvalid |-> !(out_reg.detached_now && out_reg.any_attached),
        "detach while attached")
    `HST_ASSERT(a_msg_fields,
        (m_tvalid && out_reg.accepted) |->
            (out_reg.history_to == '0 && !out_reg.detached_now && out_reg.expired_mask == '0),
        "tick fields on accepted message")

endmodule

>>> rtl/host_session_table.sv
// ----------------------------------------------------------------------------
// host_session_table
// Remote host session table with LRU replacement and idle expiry.
// ----------------------------------------------------------------------------
// Each item (hello, data, bye, reset or tick) is handled in steps: it is
// accepted, the table is scanned one entry a cycle through a single
// match/age compare unit, the update is applied, and the result register is
// loaded once it can take the item. The next item is taken the cycle after
// the result is loaded, even while that result still waits on m_tready.
// idle_timeout_us resets to 5000000 and must be written only while no item is
// in progress.
// ----------------------------------------------------------------------------
module host_session_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hst_pkg::TMO_W-1:0]     cfg_wdata,   // idle_timeout_us
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hst_pkg::KIND_W-1:0]    s_tuser,     // kind
    input  logic [hst_pkg::S_TDATA_W-1:0] s_tdata,     // session, addr_ok, now_us, pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accepted, history_to, any_attached, detached_now, expired_mask, pad
    output logic [hst_pkg::M_TDATA_W-1:0] m_tdata
);

    hst_pkg::hst_cmd_t  cmd;
    hst_pkg::hst_stat_t stat;

    hst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hst_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
